// ===== rtl/wmk_pkg.sv =====
`timescale 1ns / 1ps
package wmk_pkg;
	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 30;
	localparam int BLOCK_BITS_DEF = 32;

	localparam logic [1:0] ACT_APPEND = 2'd0;
	localparam logic [1:0] ACT_BUILD  = 2'd1;
	localparam logic [1:0] ACT_QUERY  = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_QUERY = 2'd2;
	localparam logic [1:0] ST_NOT_BUILT = 2'd3;

	localparam logic [1:0] SRC_STORE = 2'd0;
	localparam logic [1:0] SRC_P0    = 2'd1;
	localparam logic [1:0] SRC_P1    = 2'd2;
endpackage

// ===== rtl/wmk_ram.sv =====
`timescale 1ns / 1ps
module wmk_ram #(
	parameter int W  = 32,
	parameter int D  = 1024,
	parameter int AW = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/wavelet_matrix_kth_smallest.sv =====
// Append, clear, failed query and a build of an empty store: result strobe in the cycle after the request.
// Build: per value bit level, a pass over the stored items that writes bit words and prefix counts (S_P1),
// then a pass that partitions the items by that bit (S_P2). Query: per level, S_QL, S_QR, S_Q1, S_QSTEP.
// One request at a time; busy is high while a build or query runs; results cannot stall.
// Reset (arst_n low) empties the store and clears the built flag; no clearing pass.
`timescale 1ns / 1ps
module wavelet_matrix_kth_smallest import wmk_pkg::*; #(
	parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int BLOCK_BITS = BLOCK_BITS_DEF,
	localparam int CW  = $clog2(MAX_ITEMS + 1),
	localparam int AW  = $clog2(MAX_ITEMS)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            action,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [CW-1:0]         range_start,
	input  logic [CW-1:0]         range_end,
	input  logic [AW-1:0]         rank_k,
	output logic                  done,
	output logic [VALUE_BITS-1:0] answer,
	output logic [1:0]            status
);
	localparam int WPL = (MAX_ITEMS + BLOCK_BITS - 1) / BLOCK_BITS;
	localparam int WB  = (WPL > 1) ? $clog2(WPL) : 1;
	localparam int HW  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int PB  = $clog2(BLOCK_BITS);
	localparam int LAW = HW + WB;
	localparam int LD  = VALUE_BITS << WB;

	typedef enum logic [2:0] {
		S_IDLE, S_P1, S_P2, S_QL, S_QR, S_Q1, S_QSTEP
	} state_t;

	state_t                state_q;
	logic [CW-1:0]         n_q;
	logic                  built_q;
	logic [HW-1:0]         lvl_q;
	logic [1:0]            src_q, dst_q;
	logic [CW-1:0]         rd_cnt_q;
	logic                  valid_s1;
	logic [CW-1:0]         idx_s1;
	logic [BLOCK_BITS-1:0] acc_q;
	logic [PB-1:0]         pos_q;
	logic [WB-1:0]         blk_q;
	logic [CW-1:0]         run_q, zeros_q, zptr_q, optr_q;
	logic [CW-1:0]         zc_q [VALUE_BITS];
	logic [CW-1:0]         l_q, r_q, onel_q, oner_q;
	logic [AW-1:0]         k_q;
	logic [VALUE_BITS-1:0] ans_q;

	logic [VALUE_BITS-1:0] st_rd, p0_rd, p1_rd, src_rd;
	logic [BLOCK_BITS-1:0] word_rd;
	logic [CW-1:0]         pref_rd;
	logic                  st_we, p0_we, p1_we, lw_we;
	logic [AW-1:0]         dst_addr;
	logic [LAW-1:0]        lw_raddr, lp_raddr, lw_waddr;
	logic                  issue, bit_s1, flush;
	logic [BLOCK_BITS-1:0] acc_nx;
	logic [CW-1:0]         run_nx, zeros_nx;
	logic [CW-1:0]         ridx, rblk, rank_v, pop_v;
	logic [PB-1:0]         rrem;
	logic [BLOCK_BITS-1:0] rmask;
	logic [CW-1:0]         zl, zr, have;

	assign issue  = (state_q == S_P1 || state_q == S_P2) && (rd_cnt_q != n_q);
	assign src_rd = (src_q == SRC_STORE) ? st_rd : ((src_q == SRC_P0) ? p0_rd : p1_rd);
	assign bit_s1 = src_rd[lvl_q];
	assign acc_nx = acc_q | (BLOCK_BITS'(bit_s1) << pos_q);
	assign run_nx = run_q + CW'(bit_s1);
	assign zeros_nx = zeros_q + CW'(!bit_s1);
	assign flush  = (pos_q == PB'(BLOCK_BITS - 1)) || (idx_s1 == n_q - CW'(1));

	assign st_we    = (state_q == S_IDLE) && start && (action == ACT_APPEND)
		&& (n_q < CW'(MAX_ITEMS));
	assign p0_we    = (state_q == S_P2) && valid_s1 && (dst_q == SRC_P0);
	assign p1_we    = (state_q == S_P2) && valid_s1 && (dst_q == SRC_P1);
	assign dst_addr = bit_s1 ? optr_q[AW-1:0] : zptr_q[AW-1:0];
	assign lw_we    = (state_q == S_P1) && valid_s1 && flush;
	assign lw_waddr = {lvl_q, blk_q};

	assign ridx  = (state_q == S_QL) ? l_q : r_q;
	assign rblk  = ridx >> PB;
	assign lw_raddr = {lvl_q, rblk[WB-1:0]};
	assign lp_raddr = {lvl_q, WB'(rblk - CW'(1))};

	// rank on the read data, for the index of the previous cycle
	always_comb begin
		logic [CW-1:0] blk_c;
		blk_c = ((state_q == S_QR) ? l_q : r_q) >> PB;
		rrem  = PB'(((state_q == S_QR) ? l_q : r_q) % BLOCK_BITS);
		rmask = (BLOCK_BITS'(1) << rrem) - BLOCK_BITS'(1);
		pop_v = '0;
		for (int b = 0; b < BLOCK_BITS; b++) begin
			pop_v = pop_v + CW'(word_rd[b] & rmask[b]);
		end
		rank_v = (blk_c != '0) ? pref_rd : '0;
		if (rrem != '0 && blk_c < CW'(WPL)) begin
			rank_v = rank_v + pop_v;
		end
	end

	assign zl   = l_q - onel_q;
	assign zr   = r_q - oner_q;
	assign have = zr - zl;

	wmk_ram #(.W(VALUE_BITS), .D(MAX_ITEMS), .AW(AW)) u_store (
		.clk(clk), .we(st_we), .waddr(n_q[AW-1:0]), .wdata(value),
		.raddr(rd_cnt_q[AW-1:0]), .rdata(st_rd)
	);
	wmk_ram #(.W(VALUE_BITS), .D(MAX_ITEMS), .AW(AW)) u_part0 (
		.clk(clk), .we(p0_we), .waddr(dst_addr), .wdata(src_rd),
		.raddr(rd_cnt_q[AW-1:0]), .rdata(p0_rd)
	);
	wmk_ram #(.W(VALUE_BITS), .D(MAX_ITEMS), .AW(AW)) u_part1 (
		.clk(clk), .we(p1_we), .waddr(dst_addr), .wdata(src_rd),
		.raddr(rd_cnt_q[AW-1:0]), .rdata(p1_rd)
	);
	wmk_ram #(.W(BLOCK_BITS), .D(LD), .AW(LAW)) u_words (
		.clk(clk), .we(lw_we), .waddr(lw_waddr), .wdata(acc_nx),
		.raddr(lw_raddr), .rdata(word_rd)
	);
	wmk_ram #(.W(CW), .D(LD), .AW(LAW)) u_prefix (
		.clk(clk), .we(lw_we), .waddr(lw_waddr), .wdata(run_nx),
		.raddr(lp_raddr), .rdata(pref_rd)
	);

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			built_q  <= 1'b0;
			done     <= 1'b0;
			valid_s1 <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			done     <= 1'b0;
			valid_s1 <= issue;
			idx_s1   <= rd_cnt_q;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CW'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						answer <= '0;
						status <= ST_OK;
						unique case (action)
							ACT_APPEND: begin
								done <= 1'b1;
								if (n_q >= CW'(MAX_ITEMS)) begin
									status <= ST_FULL;
								end else begin
									n_q     <= n_q + CW'(1);
									built_q <= 1'b0;
								end
							end
							ACT_BUILD: begin
								if (n_q == '0) begin
									built_q <= 1'b1;
									done    <= 1'b1;
								end else begin
									lvl_q    <= HW'(VALUE_BITS - 1);
									src_q    <= SRC_STORE;
									dst_q    <= SRC_P0;
									rd_cnt_q <= '0;
									acc_q    <= '0;
									pos_q    <= '0;
									blk_q    <= '0;
									run_q    <= '0;
									zeros_q  <= '0;
									state_q  <= S_P1;
								end
							end
							ACT_QUERY: begin
								if (!built_q) begin
									status <= ST_NOT_BUILT;
									done   <= 1'b1;
								end else if (range_start > range_end || range_end > n_q
									|| CW'(rank_k) >= range_end - range_start) begin
									status <= ST_BAD_QUERY;
									done   <= 1'b1;
								end else begin
									l_q     <= range_start;
									r_q     <= range_end;
									k_q     <= rank_k;
									ans_q   <= '0;
									lvl_q   <= HW'(VALUE_BITS - 1);
									state_q <= S_QL;
								end
							end
							ACT_CLEAR: begin
								n_q     <= '0;
								built_q <= 1'b0;
								done    <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				S_P1: begin
					if (valid_s1) begin
						run_q   <= run_nx;
						zeros_q <= zeros_nx;
						if (flush) begin
							acc_q <= '0;
							pos_q <= '0;
							blk_q <= blk_q + WB'(1);
						end else begin
							acc_q <= acc_nx;
							pos_q <= pos_q + PB'(1);
						end
						if (idx_s1 == n_q - CW'(1)) begin
							rd_cnt_q <= '0;
							zptr_q   <= '0;
							optr_q   <= zeros_nx;
							zc_q[lvl_q] <= zeros_nx;
							state_q  <= S_P2;
						end
					end
				end
				S_P2: begin
					if (valid_s1) begin
						if (bit_s1) begin
							optr_q <= optr_q + CW'(1);
						end else begin
							zptr_q <= zptr_q + CW'(1);
						end
						if (idx_s1 == n_q - CW'(1)) begin
							if (lvl_q == '0) begin
								built_q <= 1'b1;
								done    <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								lvl_q    <= lvl_q - HW'(1);
								src_q    <= dst_q;
								dst_q    <= (dst_q == SRC_P0) ? SRC_P1 : SRC_P0;
								rd_cnt_q <= '0;
								acc_q    <= '0;
								pos_q    <= '0;
								blk_q    <= '0;
								run_q    <= '0;
								zeros_q  <= '0;
								state_q  <= S_P1;
							end
						end
					end
				end
				S_QL: state_q <= S_QR;
				S_QR: begin
					onel_q  <= rank_v;
					state_q <= S_Q1;
				end
				S_Q1: begin
					oner_q  <= rank_v;
					state_q <= S_QSTEP;
				end
				S_QSTEP: begin
					logic [VALUE_BITS-1:0] ans_c;
					ans_c = ans_q;
					if (CW'(k_q) < have) begin
						l_q <= zl;
						r_q <= zr;
					end else begin
						ans_c = ans_q | (VALUE_BITS'(1) << lvl_q);
						k_q <= AW'(CW'(k_q) - have);
						l_q <= zc_q[lvl_q] + onel_q;
						r_q <= zc_q[lvl_q] + oner_q;
					end
					ans_q <= ans_c;
					if (lvl_q == '0) begin
						answer  <= ans_c;
						status  <= ST_OK;
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						lvl_q   <= lvl_q - HW'(1);
						state_q <= S_QL;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CW'(MAX_ITEMS)) else $error("item count beyond capacity");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> answer == '0) else $error("nonzero answer on failure");
	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_QSTEP |-> onel_q <= l_q && oner_q <= r_q && l_q <= r_q)
		else $error("rank exceeds index");
	a_request_moves: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done) else $error("request dropped");
endmodule
